// File: design/cmykrgb_pkg.sv
// ----------------------------------------------------------------------------
// cmykrgb_pkg
// Shared types, corner color constants and arithmetic helpers for the
// CMYK to RGB interpolator.
// ----------------------------------------------------------------------------
package cmykrgb_pkg;

  // Number of corner weight groups carried between the two halves.
  localparam int NUM_W = 8;

  // Corner weight indexes.
  localparam int W0001 = 0;
  localparam int W0011 = 1;
  localparam int W0101 = 2;
  localparam int W0111 = 3;
  localparam int W1001 = 4;
  localparam int W1011 = 5;
  localparam int W1101 = 6;
  localparam int W1111 = 7;

  // Number of blend terms per color channel.
  localparam int NUM_T = 11;

  // Corner color coefficients.
  localparam logic [8:0] C35  = 9'd35;
  localparam logic [8:0] C31  = 9'd31;
  localparam logic [8:0] C32  = 9'd32;
  localparam logic [8:0] C28  = 9'd28;
  localparam logic [8:0] C26  = 9'd26;
  localparam logic [8:0] C243 = 9'd243;
  localparam logic [8:0] C36  = 9'd36;
  localparam logic [8:0] C237 = 9'd237;
  localparam logic [8:0] C141 = 9'd141;
  localparam logic [8:0] C34  = 9'd34;
  localparam logic [8:0] C238 = 9'd238;
  localparam logic [8:0] C15  = 9'd15;
  localparam logic [8:0] C174 = 9'd174;
  localparam logic [8:0] C240 = 9'd240;
  localparam logic [8:0] C19  = 9'd19;
  localparam logic [8:0] C167 = 9'd167;
  localparam logic [8:0] C80  = 9'd80;
  localparam logic [8:0] C2   = 9'd2;
  localparam logic [8:0] C46  = 9'd46;
  localparam logic [8:0] C49  = 9'd49;
  localparam logic [8:0] C147 = 9'd147;
  localparam logic [8:0] C54  = 9'd54;
  localparam logic [8:0] C57  = 9'd57;

  // Corner weights and black ink, handed from the weight half to the blend half.
  typedef struct packed {
    logic [NUM_W-1:0][31:0] w;
    logic [8:0]             k;
    logic                   white;
    logic                   black;
  } cmykrgb_corner_t;

  // 32-bit by 9-bit product, kept modulo 2^32.
  function automatic logic [31:0] mul_w(input logic [31:0] a, input logic [8:0] b);
    logic [40:0] p;
    p = {9'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  // Widen an 8-bit ink to the range 0..256.
  function automatic logic [8:0] widen(input logic [7:0] x);
    return {1'b0, x} + {8'd0, x[7]};
  endfunction

endpackage

// File: design/cmyk_pix_if.sv
// ----------------------------------------------------------------------------
// cmyk_pix_if
// Valid/ready channel carrying one CMYK pixel word.
// ----------------------------------------------------------------------------
interface cmyk_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] cyan;
  logic [7:0] magenta;
  logic [7:0] yellow;
  logic [7:0] black;

  modport source (output valid, output cyan, output magenta, output yellow,
                  output black, input ready);
  modport sink   (input valid, input cyan, input magenta, input yellow,
                  input black, output ready);
endinterface

// File: design/rgb_pix_if.sv
// ----------------------------------------------------------------------------
// rgb_pix_if
// Valid/ready channel carrying one RGB pixel word.
// ----------------------------------------------------------------------------
interface rgb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// File: design/cmykrgb_weights.sv
// ----------------------------------------------------------------------------
// cmykrgb_weights
// Four-stage pipeline that widens the inks and forms the eight corner
// weights of the cyan, magenta and yellow axes.
// ----------------------------------------------------------------------------
module cmykrgb_weights
  import cmykrgb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  cmyk_pix_if.sink        pixel_in,
  output logic            corner_valid,
  input  logic            corner_ready,
  output cmykrgb_corner_t corner
);

  localparam int NS = 4;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // Stage 1: widened inks and special-case flags.
  logic [8:0] c1, m1, y1, k1;
  logic       white1, black1;
  // Stage 2: cyan times magenta.
  logic [8:0]  c2, m2, y2, k2;
  logic [31:0] cm2;
  logic        white2, black2;
  // Stage 3: two-ink weights and their products with yellow.
  logic [31:0] c1m3, cm13, c1m13, cm3;
  logic [31:0] y0011, y0111, y1011, y1111;
  logic [8:0]  k3;
  logic        white3, black3;

  logic [17:0] cm_full;
  logic [31:0] c1m_n, cm1_n, c1m1_n;

  // Each stage moves when it is empty or the next one moves.
  always_comb begin
    en[NS-1] = !v[NS-1] || corner_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign pixel_in.ready = en[0];
  assign corner_valid   = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= pixel_in.valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  // Two-ink weights from the widened cyan and magenta.
  always_comb begin
    cm_full = {9'd0, c1} * {9'd0, m1};
    c1m_n   = ({23'd0, m2} << 8) - cm2;
    cm1_n   = ({23'd0, c2} << 8) - cm2;
    c1m1_n  = ((32'd256 - {23'd0, m2}) << 8) - cm1_n;
  end

  always_ff @(posedge clk) begin
    // Stage 1
    if (en[0]) begin
      c1     <= widen(pixel_in.cyan);
      m1     <= widen(pixel_in.magenta);
      y1     <= widen(pixel_in.yellow) >> 1;
      k1     <= widen(pixel_in.black);
      white1 <= (pixel_in.cyan == 8'd0) && (pixel_in.magenta == 8'd0) &&
                (pixel_in.yellow == 8'd0) && (pixel_in.black == 8'd0);
      black1 <= (pixel_in.black == 8'd255);
    end
    // Stage 2
    if (en[1]) begin
      c2     <= c1;
      m2     <= m1;
      y2     <= y1;
      k2     <= k1;
      cm2    <= {14'd0, cm_full};
      white2 <= white1;
      black2 <= black1;
    end
    // Stage 3
    if (en[2]) begin
      c1m3   <= c1m_n;
      cm13   <= cm1_n;
      c1m13  <= c1m1_n;
      cm3    <= cm2;
      y0011  <= mul_w(c1m1_n, y2);
      y0111  <= mul_w(c1m_n, y2);
      y1011  <= mul_w(cm1_n, y2);
      y1111  <= mul_w(cm2, y2);
      k3     <= k2;
      white3 <= white2;
      black3 <= black2;
    end
    // Stage 4: split each two-ink weight into its yellow and no-yellow corners.
    if (en[3]) begin
      corner.w[W0011] <= y0011;
      corner.w[W0001] <= (c1m13 << 7) - y0011;
      corner.w[W0111] <= y0111;
      corner.w[W0101] <= (c1m3 << 7) - y0111;
      corner.w[W1011] <= y1011;
      corner.w[W1001] <= (cm13 << 7) - y1011;
      corner.w[W1111] <= y1111;
      corner.w[W1101] <= (cm3 << 7) - y1111;
      corner.k        <= k3;
      corner.white    <= white3;
      corner.black    <= black3;
    end
  end

endmodule

// File: design/cmykrgb_blend.sv
// ----------------------------------------------------------------------------
// cmykrgb_blend
// Six-stage pipeline that splits each corner weight on the black axis,
// scales the corner colors and sums them into the RGB result.
// ----------------------------------------------------------------------------
module cmykrgb_blend
  import cmykrgb_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            corner_valid,
  output logic            corner_ready,
  input  cmykrgb_corner_t corner,
  rgb_pix_if.source       pixel_out
);

  localparam int NS = 6;

  logic [NS-1:0] v;
  logic [NS-1:0] en;

  // Flags travel alongside stages 1 to 5.
  logic [NS-2:0] white_p, black_p;

  // Stage 1: weight times black ink (times its complement for the last group), weight kept for stage 2.
  logic [31:0] hi1 [NUM_W];
  logic [31:0] w1  [NUM_W];
  // Stage 2: scaled high parts and full low parts; the last group holds
  // its already shifted no-black share.
  logic [31:0] hs2 [NUM_W];
  logic [31:0] lo2 [NUM_W];
  // Stage 3: coefficient products per channel.
  logic [31:0] term3 [3][NUM_T];
  logic [31:0] term_n [3][NUM_T];
  // Stage 4: partial sums.
  logic [31:0] part4 [3][3];
  // Stage 5: channel accumulators.
  logic [31:0] acc5 [3];
  logic [31:0] fin  [3];
  logic [7:0]  chan [3];

  logic [8:0] nk;

  always_comb begin
    en[NS-1] = !v[NS-1] || pixel_out.ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign corner_ready    = en[0];
  assign pixel_out.valid = v[NS-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= corner_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign nk = 9'(10'd256 - {1'b0, corner.k});

  // Coefficient products for red, green and blue.
  always_comb begin
    // Red
    term_n[0][0]  = lo2[W0001];
    term_n[0][1]  = mul_w(hs2[W0001], C35);
    term_n[0][2]  = mul_w(hs2[W0011], C28);
    term_n[0][3]  = lo2[W0011];
    term_n[0][4]  = mul_w(hs2[W0101], C36);
    term_n[0][5]  = mul_w(lo2[W0101] >> 8, C237);
    term_n[0][6]  = mul_w(hs2[W0111], C34);
    term_n[0][7]  = mul_w(lo2[W0111] >> 8, C238);
    term_n[0][8]  = mul_w(lo2[W1101] >> 8, C46);
    term_n[0][9]  = mul_w(lo2[W1111], C54);
    term_n[0][10] = 32'd0;
    // Green
    term_n[1][0]  = lo2[W0001];
    term_n[1][1]  = mul_w(hs2[W0001], C31);
    term_n[1][2]  = mul_w(hs2[W0011], C26);
    term_n[1][3]  = mul_w(lo2[W0011] >> 8, C243);
    term_n[1][4]  = mul_w(lo2[W0111] >> 8, C28);
    term_n[1][5]  = mul_w(hs2[W1001], C15);
    term_n[1][6]  = mul_w(lo2[W1001] >> 8, C174);
    term_n[1][7]  = mul_w(hs2[W1011], C19);
    term_n[1][8]  = mul_w(lo2[W1011] >> 8, C167);
    term_n[1][9]  = mul_w(lo2[W1101] >> 8, C49);
    term_n[1][10] = mul_w(lo2[W1111], C54);
    // Blue
    term_n[2][0]  = lo2[W0001];
    term_n[2][1]  = mul_w(hs2[W0001], C32);
    term_n[2][2]  = mul_w(lo2[W0101] >> 8, C141);
    term_n[2][3]  = mul_w(lo2[W0111] >> 8, C36);
    term_n[2][4]  = mul_w(hs2[W1001], C36);
    term_n[2][5]  = mul_w(lo2[W1001] >> 8, C240);
    term_n[2][6]  = mul_w(lo2[W1011] >> 8, C80);
    term_n[2][7]  = mul_w(hs2[W1101], C2);
    term_n[2][8]  = mul_w(lo2[W1101] >> 8, C147);
    term_n[2][9]  = mul_w(lo2[W1111], C57);
    term_n[2][10] = 32'd0;
  end

  // Final scaling and special-case selection.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      fin[ch] = acc5[ch] - (acc5[ch] >> 8);
      if (white_p[NS-2]) begin
        chan[ch] = 8'd255;
      end else if (black_p[NS-2]) begin
        chan[ch] = 8'd0;
      end else begin
        chan[ch] = fin[ch][30:23];
      end
    end
  end

  always_ff @(posedge clk) begin
    // Stage 1
    if (en[0]) begin
      for (int g = 0; g < NUM_W; g++) begin
        w1[g]  <= corner.w[g];
        hi1[g] <= mul_w(corner.w[g], (g == W1111) ? nk : corner.k);
      end
      white_p[0] <= corner.white;
      black_p[0] <= corner.black;
    end
    // Stage 2
    if (en[1]) begin
      for (int g = 0; g < NUM_W; g++) begin
        hs2[g] <= hi1[g] >> 8;
        lo2[g] <= (g == W1111) ? (hi1[g] >> 8) : ((w1[g] << 8) - hi1[g]);
      end
    end
    // Stage 3
    if (en[2]) begin
      for (int ch = 0; ch < 3; ch++) begin
        for (int t = 0; t < NUM_T; t++) begin
          term3[ch][t] <= term_n[ch][t];
        end
      end
    end
    // Stage 4
    if (en[3]) begin
      for (int ch = 0; ch < 3; ch++) begin
        part4[ch][0] <= term3[ch][0] + term3[ch][1] + term3[ch][2] + term3[ch][3];
        part4[ch][1] <= term3[ch][4] + term3[ch][5] + term3[ch][6] + term3[ch][7];
        part4[ch][2] <= term3[ch][8] + term3[ch][9] + term3[ch][10];
      end
    end
    // Stage 5
    if (en[4]) begin
      for (int ch = 0; ch < 3; ch++) begin
        acc5[ch] <= part4[ch][0] + part4[ch][1] + part4[ch][2];
      end
    end
    // Stage 6: output register.
    if (en[5]) begin
      pixel_out.red   <= chan[0];
      pixel_out.green <= chan[1];
      pixel_out.blue  <= chan[2];
    end
    // Flags follow stages 2 to 5.
    for (int i = 1; i < NS - 1; i++) begin
      if (en[i]) begin
        white_p[i] <= white_p[i-1];
        black_p[i] <= black_p[i-1];
      end
    end
  end

endmodule

// File: design/cmyk_to_rgb_interpolator_top.sv
// ----------------------------------------------------------------------------
// cmyk_to_rgb_interpolator_top
// CMYK to RGB conversion by multilinear interpolation over sixteen corner
// colors, as a ten-stage pipeline.
//
//   channel     dir   word                          handshake
//   pixel_in    in    cyan, magenta, yellow, black  valid/ready
//   pixel_out   out   red, green, blue              valid/ready
//
// One pixel enters per cycle while the output does not stall. The pipeline
// follows the multiply chain: ink widening, ink product, yellow split, black
// split, coefficient scaling, then a two-level adder tree and the output reg.
// Each stage holds its word while the next stage is full and stalled, so
// bubbles are squeezed out and a stalled output still lets earlier stages
// fill. Synchronous reset clears only the stage valid bits.
// ----------------------------------------------------------------------------
module cmyk_to_rgb_interpolator_top
  import cmykrgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  cmyk_pix_if.sink   pixel_in,
  rgb_pix_if.source  pixel_out
);

  logic            corner_valid;
  logic            corner_ready;
  cmykrgb_corner_t corner;

  // Ink widening and corner weights.
  cmykrgb_weights u_weights (
    .clk          (clk),
    .rst          (rst),
    .pixel_in     (pixel_in),
    .corner_valid (corner_valid),
    .corner_ready (corner_ready),
    .corner       (corner)
  );

  // Black split, color scaling and accumulation.
  cmykrgb_blend u_blend (
    .clk          (clk),
    .rst          (rst),
    .corner_valid (corner_valid),
    .corner_ready (corner_ready),
    .corner       (corner),
    .pixel_out    (pixel_out)
  );

endmodule

// File: verif/tb_cmyk_to_rgb_interpolator_top.sv
// ----------------------------------------------------------------------------
// tb_cmyk_to_rgb_interpolator_top
// Self-checking bench for the CMYK to RGB interpolator. A short table of
// directed pixels covers the ink extremes, the white and full-black cases
// and the widening boundary. Random pixels then follow under several
// idle and stall patterns. Each pixel word accepted at the input, unless a
// directed entry types its color, is run through a bit-accurate model of the
// interpolation arithmetic. Each word leaving the block is compared, channel
// by channel, with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_cmyk_to_rgb_interpolator_top;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] cyan;
    logic [7:0] magenta;
    logic [7:0] yellow;
    logic [7:0] black;
  } cmyk_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // One directed pixel; the typed color is used only when has_color is set.
  typedef struct packed {
    cmyk_t px;
    logic  has_color;
    rgb_t  color;
  } directed_pixel_t;

  localparam rgb_t WHITE = '{8'd255, 8'd255, 8'd255};
  localparam rgb_t BLACK = '{8'd0, 8'd0, 8'd0};
  localparam rgb_t UNTYPED = '{8'd0, 8'd0, 8'd0};

  localparam int NUM_DIRECTED   = 25;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 30;
  localparam int HOLD_CYCLES    = 150;

  localparam directed_pixel_t DIRECTED_PIXELS [NUM_DIRECTED] = '{
    '{'{8'd0,   8'd0,   8'd0,   8'd0},   1'b1, WHITE},
    '{'{8'd0,   8'd0,   8'd0,   8'd255}, 1'b1, BLACK},
    '{'{8'd255, 8'd255, 8'd255, 8'd255}, 1'b1, BLACK},
    '{'{8'd255, 8'd0,   8'd0,   8'd255}, 1'b1, BLACK},
    '{'{8'd0,   8'd255, 8'd0,   8'd255}, 1'b1, BLACK},
    '{'{8'd0,   8'd0,   8'd255, 8'd255}, 1'b1, BLACK},
    '{'{8'd0,   8'd0,   8'd0,   8'd1},   1'b0, UNTYPED},
    '{'{8'd0,   8'd0,   8'd0,   8'd254}, 1'b0, UNTYPED},
    '{'{8'd255, 8'd0,   8'd0,   8'd0},   1'b0, UNTYPED},
    '{'{8'd0,   8'd255, 8'd0,   8'd0},   1'b0, UNTYPED},
    '{'{8'd0,   8'd0,   8'd255, 8'd0},   1'b0, UNTYPED},
    '{'{8'd255, 8'd255, 8'd0,   8'd0},   1'b0, UNTYPED},
    '{'{8'd255, 8'd0,   8'd255, 8'd0},   1'b0, UNTYPED},
    '{'{8'd0,   8'd255, 8'd255, 8'd0},   1'b0, UNTYPED},
    '{'{8'd255, 8'd255, 8'd255, 8'd0},   1'b0, UNTYPED},
    '{'{8'd255, 8'd255, 8'd255, 8'd254}, 1'b0, UNTYPED},
    '{'{8'd127, 8'd127, 8'd127, 8'd127}, 1'b0, UNTYPED},
    '{'{8'd128, 8'd128, 8'd128, 8'd128}, 1'b0, UNTYPED},
    '{'{8'd1,   8'd0,   8'd0,   8'd0},   1'b0, UNTYPED},
    '{'{8'd0,   8'd1,   8'd0,   8'd0},   1'b0, UNTYPED},
    '{'{8'd0,   8'd0,   8'd1,   8'd0},   1'b0, UNTYPED},
    '{'{8'd1,   8'd1,   8'd1,   8'd1},   1'b0, UNTYPED},
    '{'{8'd170, 8'd85,  8'd170, 8'd85},  1'b0, UNTYPED},
    '{'{8'd85,  8'd170, 8'd85,  8'd170}, 1'b0, UNTYPED},
    '{'{8'd254, 8'd254, 8'd254, 8'd254}, 1'b0, UNTYPED}
  };

  logic clk;
  logic rst;

  cmyk_pix_if pix_in ();
  rgb_pix_if  pix_out ();

  cmyk_to_rgb_interpolator_top dut (
    .clk       (clk),
    .rst       (rst),
    .pixel_in  (pix_in),
    .pixel_out (pix_out)
  );

  rgb_t expected_rgb_q [$];
  int   pixels_in;
  int   mismatch_count;
  int   idle_cycles;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   hold_request;

  // Interpolation over the sixteen corner colors, all sums and products
  // wrapping at 32 bits.
  function automatic rgb_t interpolate_rgb(input cmyk_t px);
    bit [31:0] c, m, y, k, r, g, b;
    bit [31:0] cm, c1m, cm1, c1m1;
    bit [31:0] w0001, w0011, w0101, w0111, w1001, w1011, w1101, w1111;
    bit [31:0] hi, lo;
    rgb_t      res;
    if (px == '0) begin
      return WHITE;
    end
    if (px.black == 8'd255) begin
      return BLACK;
    end

    // Each ink is widened to 0..256; yellow is then halved.
    c = {24'd0, px.cyan} + {31'd0, px.cyan[7]};
    m = {24'd0, px.magenta} + {31'd0, px.magenta[7]};
    y = ({24'd0, px.yellow} + {31'd0, px.yellow[7]}) >> 1;
    k = {24'd0, px.black} + {31'd0, px.black[7]};

    // Corner weights from the inks and their complements.
    cm    = c * m;
    c1m   = (m << 8) - cm;
    cm1   = (c << 8) - cm;
    c1m1  = ((32'd256 - m) << 8) - cm1;
    w0011 = c1m1 * y;
    w0001 = (c1m1 << 7) - w0011;
    w0111 = c1m * y;
    w0101 = (c1m << 7) - w0111;
    w1011 = cm1 * y;
    w1001 = (cm1 << 7) - w1011;
    w1111 = cm * y;
    w1101 = (cm << 7) - w1111;

    // White and black-only corners.
    hi = w0001 * k;
    lo = (w0001 << 8) - hi;
    hi = hi >> 8;
    r = lo + 32'd35 * hi;
    g = lo + 32'd31 * hi;
    b = lo + 32'd32 * hi;

    // Yellow corners.
    hi = w0011 * k;
    lo = (w0011 << 8) - hi;
    hi = hi >> 8;
    r = r + 32'd28 * hi;
    g = g + 32'd26 * hi;
    r = r + lo;
    lo = lo >> 8;
    g = g + 32'd243 * lo;

    // Magenta corners.
    hi = w0101 * k;
    lo = ((w0101 << 8) - hi) >> 8;
    hi = hi >> 8;
    r = r + 32'd36 * hi;
    r = r + 32'd237 * lo;
    b = b + 32'd141 * lo;

    // Magenta and yellow corners.
    hi = w0111 * k;
    lo = ((w0111 << 8) - hi) >> 8;
    hi = hi >> 8;
    r = r + 32'd34 * hi;
    r = r + 32'd238 * lo;
    g = g + 32'd28 * lo;
    b = b + 32'd36 * lo;

    // Cyan corners.
    hi = w1001 * k;
    lo = ((w1001 << 8) - hi) >> 8;
    hi = hi >> 8;
    g = g + 32'd15 * hi;
    b = b + 32'd36 * hi;
    g = g + 32'd174 * lo;
    b = b + 32'd240 * lo;

    // Cyan and yellow corners.
    hi = w1011 * k;
    lo = ((w1011 << 8) - hi) >> 8;
    hi = hi >> 8;
    g = g + 32'd19 * hi;
    g = g + 32'd167 * lo;
    b = b + 32'd80 * lo;

    // Cyan and magenta corners.
    hi = w1101 * k;
    lo = ((w1101 << 8) - hi) >> 8;
    hi = hi >> 8;
    b = b + 32'd2 * hi;
    r = r + 32'd46 * lo;
    g = g + 32'd49 * lo;
    b = b + 32'd147 * lo;

    // Three-ink corner; its black corner adds nothing.
    lo = (w1111 * (32'd256 - k)) >> 8;
    r = r + 32'd54 * lo;
    g = g + 32'd54 * lo;
    b = b + 32'd57 * lo;

    r = r - (r >> 8);
    g = g - (g >> 8);
    b = b - (b >> 8);
    res.red   = r[30:23];
    res.green = g[30:23];
    res.blue  = b[30:23];
    return res;
  endfunction

  // Random ink, weighted toward zero, full and the widening boundary.
  function automatic logic [7:0] random_ink();
    unique case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(129, 126));
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic cmyk_t random_pixel();
    cmyk_t px;
    if ($urandom_range(49) == 0) begin
      px = '0;
    end else begin
      px = '{random_ink(), random_ink(), random_ink(), random_ink()};
    end
    return px;
  endfunction

  task automatic check_channel(input string name, input logic [7:0] want,
                               input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Offer one word, idling first at the current rate, and wait for acceptance.
  task automatic send_pixel(input cmyk_t px);
    while ($urandom_range(99) < send_idle_pct) begin
      pix_in.valid <= 1'b0;
      @(posedge clk);
    end
    pix_in.valid   <= 1'b1;
    pix_in.cyan    <= px.cyan;
    pix_in.magenta <= px.magenta;
    pix_in.yellow  <= px.yellow;
    pix_in.black   <= px.black;
    do @(posedge clk); while (!pix_in.ready);
  endtask

  task automatic send_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_pixel(random_pixel());
  endtask

  // Clock.
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Output side: random stalls, plus a long hold-off when requested.
  initial begin
    int hold_left;
    hold_left = 0;
    pix_out.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left != 0) begin
        pix_out.ready <= 1'b0;
        hold_left--;
      end else begin
        pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Predict on every accepted input word, check every accepted output word,
  // and stop the run if nothing moves for too long.
  always @(posedge clk) begin
    rgb_t want;
    bit   moved;
    moved = 1'b0;
    if (!rst) begin
      if (pix_in.valid && pix_in.ready) begin
        moved = 1'b1;
        if (pixels_in < NUM_DIRECTED && DIRECTED_PIXELS[pixels_in].has_color) begin
          want = DIRECTED_PIXELS[pixels_in].color;
        end else begin
          want = interpolate_rgb({pix_in.cyan, pix_in.magenta, pix_in.yellow,
                                  pix_in.black});
        end
        expected_rgb_q.push_back(want);
        pixels_in++;
      end
      if (pix_out.valid && pix_out.ready) begin
        moved = 1'b1;
        if (expected_rgb_q.size() == 0) begin
          $display("%0t: unexpected word, expected none, got %0d %0d %0d", $time,
                   pix_out.red, pix_out.green, pix_out.blue);
          mismatch_count++;
        end else begin
          want = expected_rgb_q.pop_front();
          check_channel("red", want.red, pix_out.red);
          check_channel("green", want.green, pix_out.green);
          check_channel("blue", want.blue, pix_out.blue);
        end
      end
      if (moved) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Stimulus.
  initial begin
    pixels_in      = 0;
    mismatch_count = 0;
    idle_cycles    = 0;
    hold_request   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst            <= 1'b1;
    pix_in.valid   <= 1'b0;
    pix_in.cyan    <= 8'd0;
    pix_in.magenta <= 8'd0;
    pix_in.yellow  <= 8'd0;
    pix_in.black   <= 8'd0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed pixels, back to back.
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_pixel(DIRECTED_PIXELS[i].px);
    end

    send_random(200, 0, 0);

    // Long output hold-off while words keep coming, so the pipe fills.
    hold_request = HOLD_CYCLES;
    send_random(40, 0, 0);

    // Input pause until every prediction has been matched.
    pix_in.valid <= 1'b0;
    while (expected_rgb_q.size() != 0) @(posedge clk);

    send_random(250, 69, 0);
    send_random(250, 0, 69);
    send_random(250, 27, 27);
    send_random(140, 0, 0);
    pix_in.valid <= 1'b0;

    // Drain, then give any stray word time to show up.
    while (expected_rgb_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
design/cmykrgb_pkg.sv
design/cmyk_pix_if.sv
design/rgb_pix_if.sv
design/cmykrgb_weights.sv
design/cmykrgb_blend.sv
design/cmyk_to_rgb_interpolator_top.sv
verif/tb_cmyk_to_rgb_interpolator_top.sv
